@@ sv/avtp_pkg.sv @@
package avtp_pkg;

	// Ring size in bytes. It must be a power of two, so that a ring offset is a mask.
	localparam int unsigned RING_BYTES = 8192;
	localparam int unsigned MAX_BURST_DEF = 32;
	localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;

	localparam int unsigned OFF_W = 13;
	localparam int unsigned PADDR_W = 5;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_FRAME_BYTES = 3'd0;
	localparam logic [2:0] REG_FRAMES_PER_PACKET = 3'd1;
	localparam logic [2:0] REG_PACKET_PERIOD = 3'd2;
	localparam logic [2:0] REG_TRANSIT = 3'd3;
	localparam logic [2:0] REG_UNCERTAINTY = 3'd4;
	localparam logic [2:0] REG_IEC_MODE = 3'd5;

	typedef struct packed {
		logic [8:0] frame_bytes;
		logic [6:0] frames_per_packet;
		logic [31:0] packet_period_ns;
		logic [31:0] transit_ns;
		logic [31:0] uncertainty_ns;
		logic iec_mode;
	} cfg_t;

	typedef struct packed {
		logic load_in;
		logic do_write;
		logic emit_stat;
		logic emit_desc;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic has_pkt;
		logic more_pkt;
	} sts_t;

	function automatic logic [OFF_W-1:0] ring_off(input logic [31:0] idx);
		logic [31:0] m;
		m = idx & 32'(RING_BYTES - 1);
		return m[OFF_W-1:0];
	endfunction

endpackage

@@ sv/avtp_talker_pdu_scheduler.sv @@
// The write status is loaded into the output register after the S_WRITE and
// S_STAT steps; S_STAT waits while the output register holds a result not taken.
// Each item gives one write status, then N descriptors (0 to MAX_BURST), one
// descriptor a cycle through a single output register while that register is free.
// Reset: arst_n clears ring indices, stream time, counters and the output
// valid; configuration registers return to their default values.
module avtp_talker_pdu_scheduler
	import avtp_pkg::*;
#(
	parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [13:0]        byte_count,
	input  logic [63:0]        now_ns,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic               overrun,
	output logic [OFF_W-1:0]   write_offset,
	output logic [OFF_W-1:0]   read_offset,
	output logic [7:0]         sequence_res,
	output logic [63:0]        launch_time,
	output logic [31:0]        presentation_stamp,
	output logic [7:0]         block_count,
	output logic               last
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	avtp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	avtp_ctrl #(
		.MAX_BURST (MAX_BURST)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	avtp_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg),
		.cmd                (cmd),
		.sts                (sts),
		.byte_count         (byte_count),
		.now_ns             (now_ns),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.kind               (kind),
		.overrun            (overrun),
		.write_offset       (write_offset),
		.read_offset        (read_offset),
		.sequence_res       (sequence_res),
		.launch_time        (launch_time),
		.presentation_stamp (presentation_stamp),
		.block_count        (block_count),
		.last               (last)
	);

endmodule

@@ sv/avtp_cfg_regs.sv @@
module avtp_cfg_regs
	import avtp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign wr_en = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_bytes <= 9'd32;
			cfg_q.frames_per_packet <= 7'd6;
			cfg_q.packet_period_ns <= 32'd125000;
			cfg_q.transit_ns <= 32'd2000000;
			cfg_q.uncertainty_ns <= 32'd0;
			cfg_q.iec_mode <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FRAME_BYTES: cfg_q.frame_bytes <= pwdata[8:0];
				REG_FRAMES_PER_PACKET: cfg_q.frames_per_packet <= pwdata[6:0];
				REG_PACKET_PERIOD: cfg_q.packet_period_ns <= pwdata;
				REG_TRANSIT: cfg_q.transit_ns <= pwdata;
				REG_UNCERTAINTY: cfg_q.uncertainty_ns <= pwdata;
				REG_IEC_MODE: cfg_q.iec_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FRAME_BYTES: prdata = {23'd0, cfg_q.frame_bytes};
			REG_FRAMES_PER_PACKET: prdata = {25'd0, cfg_q.frames_per_packet};
			REG_PACKET_PERIOD: prdata = cfg_q.packet_period_ns;
			REG_TRANSIT: prdata = cfg_q.transit_ns;
			REG_UNCERTAINTY: prdata = cfg_q.uncertainty_ns;
			REG_IEC_MODE: prdata = {31'd0, cfg_q.iec_mode};
			default: prdata = 32'd0;
		endcase
	end

endmodule

@@ sv/avtp_ctrl.sv @@
module avtp_ctrl
	import avtp_pkg::*;
#(
	parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam int unsigned CW = $clog2(MAX_BURST + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WRITE = 2'd1;
	localparam logic [1:0] S_STAT = 2'd2;
	localparam logic [1:0] S_DESC = 2'd3;

	logic [1:0] state_q, state_d;
	logic [CW-1:0] burst_q, burst_d;
	logic burst_end;

	assign in_ready = (state_q == S_IDLE);
	assign burst_end = (burst_q == CW'(MAX_BURST - 1));

	always_comb begin
		state_d = state_q;
		burst_d = burst_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.do_write = 1'b1;
				state_d = S_STAT;
			end
			S_STAT: begin
				if (sts.out_free) begin
					cmd.emit_stat = 1'b1;
					cmd.last = !sts.has_pkt;
					burst_d = '0;
					state_d = sts.has_pkt ? S_DESC : S_IDLE;
				end
			end
			S_DESC: begin
				if (sts.out_free) begin
					cmd.emit_desc = 1'b1;
					cmd.last = !sts.more_pkt || burst_end;
					burst_d = burst_q + CW'(1);
					if (cmd.last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			burst_q <= '0;
		end else begin
			state_q <= state_d;
			burst_q <= burst_d;
		end
	end

	a_accept_to_write: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_WRITE))
		else $error("accepted item did not start the write step");

	a_burst_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DESC) |-> (burst_q < CW'(MAX_BURST)))
		else $error("descriptor burst ran past its limit");

endmodule

@@ sv/avtp_datapath.sv @@
module avtp_datapath
	import avtp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [13:0]      byte_count,
	input  logic [63:0]      now_ns,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             kind,
	output logic             overrun,
	output logic [OFF_W-1:0] write_offset,
	output logic [OFF_W-1:0] read_offset,
	output logic [7:0]       sequence_res,
	output logic [63:0]      launch_time,
	output logic [31:0]      presentation_stamp,
	output logic [7:0]       block_count,
	output logic             last
);

	localparam logic [31:0] RING = 32'(RING_BYTES);

	logic [13:0] count_q;
	logic [63:0] now_q;
	logic [31:0] write_index_q, read_index_q;
	logic [63:0] stream_time_q;
	logic [7:0] seq_q, blk_q;
	logic [15:0] pb_q;
	logic accept_q;
	logic [OFF_W-1:0] woff_hold_q;

	logic out_valid_q, kind_q, overrun_q, last_q;
	logic [OFF_W-1:0] woff_q, roff_q;
	logic [7:0] seq_res_q, blk_res_q;
	logic [63:0] launch_q;
	logic [31:0] pres_q;

	logic [31:0] fill;
	logic fits;
	logic stale;
	logic load_out;

	assign fill = write_index_q - read_index_q;
	assign fits = (fill <= RING) && ({18'd0, count_q} <= RING - fill);
	assign stale = (now_q - stream_time_q) > NS_PER_SECOND;
	assign load_out = cmd.emit_stat || cmd.emit_desc;

	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.has_pkt = (pb_q != 16'd0) && (fill >= {16'd0, pb_q});
	assign sts.more_pkt = fill >= {15'd0, pb_q, 1'b0};

	always_ff @(posedge clk) begin
		pb_q <= {7'd0, cfg.frame_bytes} * {9'd0, cfg.frames_per_packet};
		if (cmd.load_in) begin
			count_q <= byte_count;
			now_q <= now_ns;
		end
		if (cmd.do_write) begin
			accept_q <= fits;
			woff_hold_q <= fits ? ring_off(write_index_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q <= '0;
			read_index_q <= '0;
			stream_time_q <= '0;
			seq_q <= '0;
			blk_q <= '0;
		end else if (cmd.do_write) begin
			if (fits) begin
				write_index_q <= write_index_q + {18'd0, count_q};
			end
			if (stale) begin
				stream_time_q <= now_q;
			end
		end else if (cmd.emit_desc) begin
			seq_q <= seq_q + 8'd1;
			stream_time_q <= stream_time_q + {32'd0, cfg.packet_period_ns};
			read_index_q <= read_index_q + {16'd0, pb_q};
			if (cfg.iec_mode) begin
				blk_q <= blk_q + 8'(cfg.frames_per_packet);
			end
		end
	end

	// Output register: the next result is loaded when the register is empty or the current one is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_stat) begin
			kind_q <= 1'b0;
			overrun_q <= !accept_q;
			woff_q <= woff_hold_q;
			roff_q <= '0;
			seq_res_q <= '0;
			launch_q <= '0;
			pres_q <= '0;
			blk_res_q <= '0;
			last_q <= cmd.last;
		end else if (cmd.emit_desc) begin
			kind_q <= 1'b1;
			overrun_q <= 1'b0;
			woff_q <= '0;
			roff_q <= ring_off(read_index_q);
			seq_res_q <= seq_q;
			launch_q <= stream_time_q + {32'd0, cfg.uncertainty_ns};
			pres_q <= stream_time_q[31:0] + cfg.uncertainty_ns + cfg.transit_ns;
			blk_res_q <= blk_q;
			last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign overrun = overrun_q;
	assign write_offset = woff_q;
	assign read_offset = roff_q;
	assign sequence_res = seq_res_q;
	assign launch_time = launch_q;
	assign presentation_stamp = pres_q;
	assign block_count = blk_res_q;
	assign last = last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(write_index_q - read_index_q) <= RING)
		else $error("ring fill exceeds the ring size");

	a_read_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_desc |=> (read_index_q == $past(read_index_q) + {16'd0, $past(pb_q)}))
		else $error("read index did not advance by one packet");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> sts.out_free)
		else $error("result loaded over one not yet transferred");

endmodule
